// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, types and control codes of the peak detector.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_WINDOW);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Per-cycle command to the row of cells.
  typedef struct packed {
    logic push;    // shift toward the old end, new word enters cell 0
    logic rotate;  // shift toward cell 0, cell 0 wraps to the last cell
  } cell_ctrl_t;

endpackage

// File: rtl/core/psd_cell.sv
// ----------------------------------------------------------------------------
// psd_cell
// One window slot: takes its newer-side neighbor on a push, its older-side neighbor on a rotate, else holds.
// ----------------------------------------------------------------------------
module psd_cell (
  input  logic                 clk,
  input  psd_pkg::cell_ctrl_t  ctrl,
  input  psd_pkg::sample_t     push_in,
  input  psd_pkg::sample_t     rot_in,
  output psd_pkg::sample_t     q
);

  psd_pkg::sample_t q_next;

  always_comb begin
    q_next = q;
    if (ctrl.push) begin
      q_next = push_in;
    end else if (ctrl.rotate) begin
      q_next = rot_in;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// File: rtl/core/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: fill tracking, scan of the rotating row, result register.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cfg_wr_en,
  input  logic [psd_pkg::LEN_W-1:0]    cfg_wr_data,
  input  psd_pkg::sample_t             tap,
  output psd_pkg::cell_ctrl_t          cell_ctrl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_peak,
  output psd_pkg::sample_t             center_sample,
  output logic                         window_full
);

  psd_pkg::state_t                state, state_next;
  logic [psd_pkg::LEN_W-1:0]      window_length;
  logic [psd_pkg::CNT_W-1:0]      fill_count;
  logic [psd_pkg::CNT_W-1:0]      count;
  logic [psd_pkg::IDX_W-1:0]      cidx;
  logic                           full;
  logic [psd_pkg::IDX_W-1:0]      step;
  logic                           have_other;
  psd_pkg::sample_t               center;
  psd_pkg::sample_t               max_other;

  logic [psd_pkg::CNT_W-1:0]      len_eff;
  logic [psd_pkg::CNT_W:0]        fill_inc;
  logic [psd_pkg::CNT_W-1:0]      count_next;
  logic [psd_pkg::CNT_W-1:0]      cm1;
  logic                           accept;
  logic                           load;
  logic                           last_step;
  logic                           peak_calc;

  // Clamp the register to 1..MAX_WINDOW.
  always_comb begin
    if (window_length == '0) begin
      len_eff = psd_pkg::CNT_W'(1);
    end else if ({1'b0, window_length} > (psd_pkg::LEN_W+1)'(psd_pkg::MAX_WINDOW)) begin
      len_eff = psd_pkg::CNT_W'(psd_pkg::MAX_WINDOW);
    end else begin
      len_eff = psd_pkg::CNT_W'(window_length);
    end
  end

  always_comb begin
    fill_inc = {1'b0, fill_count} + (psd_pkg::CNT_W+1)'(1);
    if (fill_inc > {1'b0, len_eff}) begin
      count_next = len_eff;
    end else begin
      count_next = fill_inc[psd_pkg::CNT_W-1:0];
    end
    cm1 = count_next - psd_pkg::CNT_W'(1);
  end

  assign last_step = (step == psd_pkg::IDX_W'(psd_pkg::MAX_WINDOW - 1));
  assign peak_calc = full && (!have_other || (center > max_other));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      psd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = psd_pkg::ST_SCAN;
        end
      end
      psd_pkg::ST_SCAN: begin
        if (last_step) begin
          state_next = psd_pkg::ST_DONE;
        end
      end
      psd_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = psd_pkg::ST_IDLE;
        end
      end
      default: state_next = psd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine; no word is taken while reset is held
  always_comb begin
    in_ready         = 1'b0;
    cell_ctrl.push   = 1'b0;
    cell_ctrl.rotate = 1'b0;
    load             = 1'b0;
    case (state)
      psd_pkg::ST_IDLE: begin
        in_ready       = !rst;
        cell_ctrl.push = in_valid && !rst;
      end
      psd_pkg::ST_SCAN: begin
        cell_ctrl.rotate = 1'b1;
      end
      psd_pkg::ST_DONE: begin
        load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= psd_pkg::ST_IDLE;
      window_length <= psd_pkg::LEN_RESET;
      fill_count    <= '0;
      out_valid     <= 1'b0;
      have_other    <= 1'b0;
      step          <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      if (accept) begin
        fill_count <= count_next;
        have_other <= 1'b0;
        step       <= '0;
      end else if (state == psd_pkg::ST_SCAN) begin
        step <= step + psd_pkg::IDX_W'(1);
        // tap holds the entry at index step
        if (step != cidx && {1'b0, step} < count) begin
          if (!have_other || tap > max_other) begin
            have_other <= 1'b1;
          end
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      count <= count_next;
      cidx  <= psd_pkg::IDX_W'(cm1 - (cm1 >> 1));
      full  <= (count_next == len_eff);
    end
    if (state == psd_pkg::ST_SCAN) begin
      if (step == cidx) begin
        center <= tap;
      end else if ({1'b0, step} < count && (!have_other || tap > max_other)) begin
        max_other <= tap;
      end
    end
    if (load) begin
      is_peak       <= peak_calc;
      center_sample <= center;
      window_full   <= full;
    end
  end

endmodule

// File: rtl/core/sliding_window_peak_detector.sv
// Flow: an accepted word is pushed into the cell row, the row is then scanned
//   as it rotates, and the result is then loaded into the output register.
// A new word is not taken until the scan and the result load are done.
// A new word is taken while the previous result still waits on the output.
// Reset (rst, synchronous, active high): window empty, window_length = 64,
//   no result pending. Window contents are not cleared.
// ----------------------------------------------------------------------------
// sliding_window_peak_detector
// Sliding-window local maximum: on a full window, flags a word whose window
// center is strictly above every other word held in the window.
// ----------------------------------------------------------------------------
module sliding_window_peak_detector (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [psd_pkg::LEN_W-1:0]  cfg_wr_data,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         sample,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_peak,
  output logic signed [31:0]         center_sample,
  output logic                       window_full
);

  // Row of cells, cell 0 is the newest word. A push shifts the row toward
  // the old end. During a scan the row rotates toward cell 0, so cell 0
  // shows entry k at scan step k; after MAX_WINDOW steps the row is back in
  // its original order.
  psd_pkg::sample_t    row [psd_pkg::MAX_WINDOW];
  psd_pkg::cell_ctrl_t cell_ctrl;

  for (genvar i = 0; i < psd_pkg::MAX_WINDOW; i++) begin : g_cell
    psd_pkg::sample_t push_in;
    psd_pkg::sample_t rot_in;

    if (i == 0) begin : g_head
      assign push_in = sample;
    end else begin : g_body
      assign push_in = row[i-1];
    end

    // the last cell takes cell 0's word during rotation
    if (i == psd_pkg::MAX_WINDOW - 1) begin : g_tail
      assign rot_in = row[0];
    end else begin : g_mid
      assign rot_in = row[i+1];
    end

    psd_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .push_in (push_in),
      .rot_in  (rot_in),
      .q       (row[i])
    );
  end

  // Sequencer: tracks fill level, picks the center and the largest rival
  // from cell 0 during the scan, and holds the result word.
  psd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .tap           (row[0]),
    .cell_ctrl     (cell_ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_peak       (is_peak),
    .center_sample (center_sample),
    .window_full   (window_full)
  );

endmodule

// File: rtl/core/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       is_peak,
  input logic signed [31:0]         center_sample,
  input logic                       window_full
);

  `PSD_ASSERT(a_out_hold,
              out_valid && !out_ready |=> out_valid && $stable(center_sample) &&
                $stable(is_peak) && $stable(window_full),
              "result word changed while stalled")
  `PSD_ASSERT(a_peak_full, out_valid |-> !is_peak || window_full,
              "peak flagged on a window that is not full")
  `PSD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready,
              "input taken again while scanning")
  `PSD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result word pending after reset")

endmodule

bind sliding_window_peak_detector psd_checker u_psd_checker (.*);
